### design/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Shared constants, state encoding and controller/datapath interface types
// for the cofactor-expansion determinant core.
// ----------------------------------------------------------------------------
`default_nettype none

package mdc_pkg;

  localparam int MAX_ORDER_DEF     = 4;
  localparam int ELEMENT_WIDTH_DEF = 12;
  localparam int DET_WIDTH         = 50;
  localparam int CFG_WIDTH         = 3;
  localparam int RESET_ORDER       = 4;
  localparam int MIN_ORDER         = 2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_MUL,
    ST_STEP,
    ST_DONE
  } mdc_state_t;

  typedef struct packed {
    logic cfg_we;
    logic load_we;
    logic calc_init;
    logic search_hit;
    logic backtrack;
    logic mul_en;
    logic leaf_acc;
    logic descend;
  } mdc_cmd_t;

  typedef struct packed {
    logic last_elem;
    logic found;
    logic at_root;
    logic at_leaf;
  } mdc_status_t;

endpackage

`default_nettype wire

### design/matrix_determinant_cofactor_core.sv
// ----------------------------------------------------------------------------
// matrix_determinant_cofactor_core
// Exact determinant of a square signed integer matrix by cofactor expansion.
// ----------------------------------------------------------------------------
// Elements enter one per cycle in row-major order (start high while busy is
// low). After the last of the n*n elements, busy rises while a sequencer walks
// the cofactor tree depth first, taking each tree node through the search,
// multiply and step states and a single signed multiplier; when the walk is
// done, the determinant appears on out_determinant for exactly one
// cycle with out_valid high; the receiver cannot stall, so it must take the
// transaction in that cycle. busy falls in the following cycle. A write of
// the size register (taken only while busy is low and no element is offered)
// restarts loading at the first element; sizes below 2 act as 2 and sizes
// above the maximum order act as the maximum order.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_determinant_cofactor_core #(
  parameter int MAX_ORDER     = mdc_pkg::MAX_ORDER_DEF,
  parameter int ELEMENT_WIDTH = mdc_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [ELEMENT_WIDTH-1:0]   in_element_value,
  output logic                                   out_valid,
  output logic signed [mdc_pkg::DET_WIDTH-1:0]   out_determinant,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mdc_pkg::CFG_WIDTH-1:0]     cfg_matrix_size
);
  import mdc_pkg::*;

  mdc_cmd_t    cmd;
  mdc_status_t status;

  mdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
  );

  mdc_datapath #(
    .MAX_ORDER     (MAX_ORDER),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_matrix_size  (cfg_matrix_size),
    .in_element_value (in_element_value),
    .det              (out_determinant)
  );

  // A result transaction is a single-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // After the result the core is ready for the next matrix.
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("core still busy after delivering the result");

  // Computation only begins on an accepted element.
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted element");

endmodule

`default_nettype wire

### design/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// Element store, order register, load counter and the depth-first cofactor
// walker: per-row column candidates, used-column mask, partial products,
// one signed multiplier and the determinant accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_datapath #(
  parameter int MAX_ORDER     = mdc_pkg::MAX_ORDER_DEF,
  parameter int ELEMENT_WIDTH = mdc_pkg::ELEMENT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mdc_pkg::mdc_cmd_t                   cmd,
  output mdc_pkg::mdc_status_t                     status,
  input  wire logic [mdc_pkg::CFG_WIDTH-1:0]       cfg_matrix_size,
  input  wire logic signed [ELEMENT_WIDTH-1:0]     in_element_value,
  output logic signed [mdc_pkg::DET_WIDTH-1:0]     det
);
  import mdc_pkg::*;

  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int AW        = $clog2(DEPTH);
  localparam int LEVELS    = MAX_ORDER + 1;
  localparam int LW        = $clog2(LEVELS);
  localparam int TW        = $clog2(DEPTH + 1);
  localparam int DW        = DET_WIDTH;
  localparam int ORDER_RST = (RESET_ORDER > MAX_ORDER) ? MAX_ORDER : RESET_ORDER;

  logic signed [ELEMENT_WIDTH-1:0] mem [DEPTH];
  logic signed [ELEMENT_WIDTH-1:0] rd_data_r;

  logic [LW-1:0] order_r;
  logic [TW-1:0] total_r;
  logic [AW-1:0] load_cnt_r;
  logic [LW-1:0] level_r;

  logic [LW-1:0]          cand_r   [LEVELS];
  logic [LW-1:0]          chosen_r [LEVELS];
  logic signed [DW-1:0]   prod_r   [LEVELS];
  logic [LEVELS-1:0]      sign_r;
  logic [MAX_ORDER-1:0]   used_r;
  logic [LW-1:0]          sel_col_r;
  logic                   sel_par_r;
  logic signed [DW-1:0]   term_r;
  logic                   term_neg_r;
  logic signed [DW-1:0]   acc_r;

  logic [LW-1:0]                 cfg_order;
  logic [TW-1:0]                 cfg_total;
  logic                          found;
  logic [LW-1:0]                 found_col;
  logic                          below_par;
  logic [LW-1:0]                 cur_cand;
  logic [AW-1:0]                 rd_addr;
  logic [LW-1:0]                 level_up;
  logic [LW-1:0]                 level_dn;
  logic signed [DW+ELEMENT_WIDTH-1:0] mul_full;

  // The stored order is the written size saturated into the supported range.
  always_comb begin
    if (int'(cfg_matrix_size) < MIN_ORDER) begin
      cfg_order = LW'(MIN_ORDER);
    end else if (int'(cfg_matrix_size) > MAX_ORDER) begin
      cfg_order = LW'(MAX_ORDER);
    end else begin
      cfg_order = LW'(cfg_matrix_size);
    end
    cfg_total = TW'(int'(cfg_order) * int'(cfg_order));
  end

  // Smallest free column at or above this row's candidate; the parity of
  // free columns to its left gives the alternating cofactor sign.
  always_comb begin
    found     = 1'b0;
    found_col = '0;
    below_par = 1'b0;
    cur_cand  = cand_r[level_r];
    for (int c = MAX_ORDER - 1; c >= 0; c--) begin
      if (c >= int'(cur_cand) && c < int'(order_r) && !used_r[c]) begin
        found     = 1'b1;
        found_col = LW'(c);
      end
    end
    for (int c = 0; c < MAX_ORDER; c++) begin
      if (c < int'(found_col) && !used_r[c]) begin
        below_par = ~below_par;
      end
    end
  end

  assign level_up = level_r + LW'(1);
  assign level_dn = level_r - LW'(1);
  assign rd_addr  = AW'(int'(level_r) * int'(order_r) + int'(found_col));
  assign mul_full = prod_r[level_r] * rd_data_r;

  assign status.last_elem = (TW'(load_cnt_r) + TW'(1)) == total_r;
  assign status.found     = found;
  assign status.at_root   = (level_r == '0);
  assign status.at_leaf   = (level_up == order_r);
  assign det              = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r    <= LW'(ORDER_RST);
      total_r    <= TW'(ORDER_RST * ORDER_RST);
      load_cnt_r <= '0;
      level_r    <= '0;
    end else begin
      if (cmd.cfg_we) begin
        order_r    <= cfg_order;
        total_r    <= cfg_total;
        load_cnt_r <= '0;
      end else if (cmd.load_we) begin
        load_cnt_r <= status.last_elem ? '0 : load_cnt_r + AW'(1);
      end
      if (cmd.calc_init) begin
        level_r <= '0;
      end else if (cmd.backtrack) begin
        level_r <= level_dn;
      end else if (cmd.descend) begin
        level_r <= level_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[load_cnt_r] <= in_element_value;
    end
    if (cmd.calc_init) begin
      cand_r[0] <= '0;
      prod_r[0] <= DW'(1);
      sign_r[0] <= 1'b0;
      used_r    <= '0;
      acc_r     <= '0;
    end
    if (cmd.search_hit) begin
      rd_data_r       <= mem[rd_addr];
      sel_col_r       <= found_col;
      sel_par_r       <= below_par;
      cand_r[level_r] <= found_col + LW'(1);
    end
    if (cmd.mul_en) begin
      prod_r[level_up] <= mul_full[DW-1:0];
      sign_r[level_up] <= sign_r[level_r] ^ sel_par_r;
      term_r           <= mul_full[DW-1:0];
      term_neg_r       <= sign_r[level_r] ^ sel_par_r;
    end
    if (cmd.leaf_acc) begin
      acc_r <= term_neg_r ? acc_r - term_r : acc_r + term_r;
    end
    if (cmd.descend) begin
      chosen_r[level_r] <= sel_col_r;
      cand_r[level_up]  <= '0;
      for (int c = 0; c < MAX_ORDER; c++) begin
        if (int'(sel_col_r) == c) begin
          used_r[c] <= 1'b1;
        end
      end
    end
    if (cmd.backtrack) begin
      for (int c = 0; c < MAX_ORDER; c++) begin
        if (int'(chosen_r[level_dn]) == c) begin
          used_r[c] <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### design/mdc_ctrl.sv
// ----------------------------------------------------------------------------
// mdc_ctrl
// Sequencer for the determinant core: loads elements, then walks the
// cofactor tree one node at a time (search, multiply, step) and strobes
// the result.
// ----------------------------------------------------------------------------
`default_nettype none

module mdc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 cfg_valid,
  input  wire mdc_pkg::mdc_status_t status,
  output mdc_pkg::mdc_cmd_t         cmd,
  output logic                      busy,
  output logic                      cfg_ready,
  output logic                      out_valid
);
  import mdc_pkg::*;

  mdc_state_t state_r;
  mdc_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    cfg_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy       = 1'b0;
        // An element offered in this cycle takes precedence over a size write.
        cfg_ready  = !start;
        cmd.cfg_we = cfg_valid && !start;
        if (start) begin
          cmd.load_we = 1'b1;
          if (status.last_elem) begin
            cmd.calc_init = 1'b1;
            state_nxt     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (status.found) begin
          cmd.search_hit = 1'b1;
          state_nxt      = ST_MUL;
        end else if (status.at_root) begin
          state_nxt = ST_DONE;
        end else begin
          // Row exhausted: return to the row above and free its column.
          cmd.backtrack = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        if (status.at_leaf) begin
          cmd.leaf_acc = 1'b1;
        end else begin
          cmd.descend = 1'b1;
        end
        state_nxt = ST_SEARCH;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire
